>>> src/descending_permutation_generator_unit_macros.svh
// Assertion macros used by the permutation generator top level.
`ifndef DESCENDING_PERMUTATION_GENERATOR_UNIT_MACROS_SVH
`define DESCENDING_PERMUTATION_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define DPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define DPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dpg_pkg.sv
// Shared constants, types and functions of the permutation generator.
`timescale 1ns / 1ps

package dpg_pkg;

    localparam int DIGIT_W        = 4;
    localparam int CFG_W          = 4;
    localparam int VALUE_W        = 30;
    localparam int RADIX          = 10;
    localparam int MAX_DIGITS_DEF = 9;
    localparam logic [CFG_W-1:0] DIGIT_COUNT_RESET = 4'd3;

    // Status of one step, handed from the step logic to the control.
    typedef struct packed {
        logic emit;
        logic is_last;
        logic active_next;
    } t_step_res;

    // Weight of a decimal position; called with constant arguments only.
    function automatic logic [VALUE_W-1:0] pow10(input int p);
        logic [VALUE_W-1:0] w;
        w = VALUE_W'(1);
        for (int k = 0; k < p; k++) begin
            w = VALUE_W'(w * RADIX);
        end
        return w;
    endfunction

endpackage

>>> src/dpg_step.sv
// Previous-permutation step: restart load, pivot search, swap and suffix reversal.
`timescale 1ns / 1ps

module dpg_step #(
    parameter int MAX_DIGITS = dpg_pkg::MAX_DIGITS_DEF
) (
    input  logic                                        i_restart,
    input  logic                                        i_active,
    input  logic [dpg_pkg::CFG_W-1:0]                   i_digit_count,
    input  logic [MAX_DIGITS-1:0][dpg_pkg::DIGIT_W-1:0] i_digits,
    output logic [MAX_DIGITS-1:0][dpg_pkg::DIGIT_W-1:0] o_digits,
    output logic [MAX_DIGITS-1:0][dpg_pkg::DIGIT_W-1:0] o_aligned,
    output dpg_pkg::t_step_res                          o_res
);

    localparam int DW    = dpg_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [CNT_W-1:0]              n;
    logic                          found;
    logic [CNT_W-1:0]              piv;
    logic [CNT_W-1:0]              sw;
    logic [DW-1:0]                 piv_val;
    logic [DW-1:0]                 sw_val;
    logic [MAX_DIGITS-1:0][DW-1:0] swp;
    logic [MAX_DIGITS-1:0][DW-1:0] nxt;
    logic [MAX_DIGITS-1:0][DW-1:0] sel;
    logic                          last;
    logic                          emit;

    // Effective digit count, clamped into 1..MAX_DIGITS.
    always_comb begin
        if (i_digit_count == '0) begin
            n = CNT_W'(1);
        end else if (int'(i_digit_count) > MAX_DIGITS) begin
            n = CNT_W'(MAX_DIGITS);
        end else begin
            n = CNT_W'(i_digit_count);
        end
    end

    always_comb begin
        // The rightmost descent sets the pivot, one left of it.
        found = 1'b0;
        piv   = '0;
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (i < int'(n) && i_digits[i-1] > i_digits[i]) begin
                found = 1'b1;
                piv   = CNT_W'(i - 1);
            end
        end

        piv_val = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k == int'(piv)) begin
                piv_val = i_digits[k];
            end
        end

        // Rightmost digit right of the pivot that is smaller than it.
        sw = piv;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (j < int'(n) && j > int'(piv) && i_digits[j] < piv_val) begin
                sw = CNT_W'(j);
            end
        end

        sw_val = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k == int'(sw)) begin
                sw_val = i_digits[k];
            end
        end

        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k == int'(piv)) begin
                swp[k] = sw_val;
            end else if (k == int'(sw)) begin
                swp[k] = piv_val;
            end else begin
                swp[k] = i_digits[k];
            end
        end

        // The suffix after the pivot is reversed.
        for (int k = 0; k < MAX_DIGITS; k++) begin
            nxt[k] = swp[k];
            if (k > int'(piv) && k < int'(n)) begin
                for (int s = 0; s < MAX_DIGITS; s++) begin
                    if (s == int'(n) + int'(piv) - k) begin
                        nxt[k] = swp[s];
                    end
                end
            end
        end

        // A restart loads n..1 into the used positions.
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (i_restart && k < int'(n)) begin
                sel[k] = DW'(int'(n) - k);
            end else if (i_restart) begin
                sel[k] = i_digits[k];
            end else begin
                sel[k] = nxt[k];
            end
        end

        last = 1'b1;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k < int'(n) && sel[k] != DW'(k + 1)) begin
                last = 1'b0;
            end
        end

        // Units digit in position 0, unused upper positions zero.
        for (int p = 0; p < MAX_DIGITS; p++) begin
            o_aligned[p] = '0;
            for (int s = 0; s < MAX_DIGITS; s++) begin
                if (p < int'(n) && s == int'(n) - 1 - p) begin
                    o_aligned[p] = sel[s];
                end
            end
        end

        emit              = i_restart || (i_active && found);
        o_digits          = sel;
        o_res.emit        = emit;
        o_res.is_last     = last;
        o_res.active_next = emit && !last;
    end

endmodule

>>> src/dpg_dec_stage.sv
// Output stage: decimal weighting of the digits into the result register.
`timescale 1ns / 1ps

module dpg_dec_stage #(
    parameter int MAX_DIGITS = dpg_pkg::MAX_DIGITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic [MAX_DIGITS-1:0][dpg_pkg::DIGIT_W-1:0] i_aligned,
    input  logic                                        i_is_last,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [dpg_pkg::VALUE_W-1:0]                 o_perm_value,
    output logic                                        o_is_last
);

    localparam int VW = dpg_pkg::VALUE_W;

    logic          r_valid;
    logic [VW-1:0] r_value;
    logic          r_last;
    logic [VW-1:0] n_value;

    always_comb begin
        n_value = '0;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            n_value = VW'(n_value + VW'(i_aligned[p]) * dpg_pkg::pow10(p));
        end
    end

    assign o_in_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_value <= n_value;
            r_last  <= i_is_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_perm_value = r_value;
    assign o_is_last    = r_last;

endmodule

>>> src/descending_permutation_generator_unit.sv
// Top level of the descending permutation generator.
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ----------------------------
//  request   in         i_valid / o_stall    i_restart
//  result    out        o_valid / i_stall    o_perm_value, o_is_last
//  config    in         i_cfg_valid / ready  i_cfg_data (digit count)
//
//  One request word is taken per cycle while o_stall is low; its result word
//  passes the input register, the step register and the output register.
//  The step from one permutation to the next is one pass of combinational
//  logic over the digit store, so consecutive requests run back to back.
//  Reset clears the pipeline valids and the running flag and sets the digit
//  count to 3; the digit store is not cleared, a restart fills it.
//  A stall on the result side holds the output register, then the step
//  register, then the input register, and only then stalls requests.
`timescale 1ns / 1ps

`include "descending_permutation_generator_unit_macros.svh"

module descending_permutation_generator_unit #(
    parameter int MAX_DIGITS = dpg_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_restart,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dpg_pkg::VALUE_W-1:0]   o_perm_value,
    output logic                          o_is_last,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpg_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DW = dpg_pkg::DIGIT_W;

    // Configuration and sequence state.
    logic [dpg_pkg::CFG_W-1:0]     r_digit_count;
    logic                          r_active;
    logic [MAX_DIGITS-1:0][DW-1:0] r_digit_store;

    // Input register.
    logic                          r_in_valid;
    logic                          r_in_restart;

    // Step register, holding the digits aligned for decimal weighting.
    logic                          r_mid_valid;
    logic [MAX_DIGITS-1:0][DW-1:0] r_mid_aligned;
    logic                          r_mid_last;

    logic [MAX_DIGITS-1:0][DW-1:0] step_digits;
    logic [MAX_DIGITS-1:0][DW-1:0] step_aligned;
    dpg_pkg::t_step_res            step_res;

    logic                          dec_ready;
    logic                          mid_ready;
    logic                          in_go;
    logic                          in_ready;
    logic                          cfg_wr;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // A stage may move when it is empty or the stage after it moves.
    assign mid_ready = !r_mid_valid || dec_ready;
    assign in_go     = r_in_valid && mid_ready;
    assign in_ready  = !r_in_valid || in_go;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= dpg_pkg::DIGIT_COUNT_RESET;
        end else if (cfg_wr) begin
            r_digit_count <= i_cfg_data;
        end
    end

    // A register write ends any running sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (cfg_wr) begin
            r_active <= 1'b0;
        end else if (in_go) begin
            r_active <= step_res.active_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && step_res.emit) begin
            r_digit_store <= step_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_restart <= i_restart;
        end
    end

    // A request that yields no result leaves the step register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_ready) begin
            r_mid_valid <= in_go && step_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && step_res.emit) begin
            r_mid_aligned <= step_aligned;
            r_mid_last    <= step_res.is_last;
        end
    end

    dpg_step #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_step (
        .i_restart     (r_in_restart),
        .i_active      (r_active),
        .i_digit_count (r_digit_count),
        .i_digits      (r_digit_store),
        .o_digits      (step_digits),
        .o_aligned     (step_aligned),
        .o_res         (step_res)
    );

    dpg_dec_stage #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (r_mid_valid),
        .o_in_ready   (dec_ready),
        .i_aligned    (r_mid_aligned),
        .i_is_last    (r_mid_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_perm_value (o_perm_value),
        .o_is_last    (o_is_last)
    );

    // A restart always yields a result.
    `DPG_ASSERT_NOW(a_restart_emits, i_clk, i_rst_n, in_go && r_in_restart, step_res.emit, "restart gave no result")
    // Without a running sequence only a restart yields a result.
    `DPG_ASSERT_NOW(a_idle_silent, i_clk, i_rst_n, in_go && !r_in_restart && !r_active, !step_res.emit, "result without running sequence")
    // The smallest permutation ends the sequence.
    `DPG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, in_go && step_res.emit && step_res.is_last, !r_active, "sequence still running after last")
    // A register write ends the sequence.
    `DPG_ASSERT_NEXT(a_cfg_ends, i_clk, i_rst_n, cfg_wr, !r_active, "sequence still running after config write")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the descending permutation generator unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int DIGIT_W           = dpg_pkg::DIGIT_W;
    localparam int CFG_W             = dpg_pkg::CFG_W;
    localparam int VALUE_W           = dpg_pkg::VALUE_W;
    localparam int RADIX             = dpg_pkg::RADIX;
    localparam logic [CFG_W-1:0] DIGIT_COUNT_RESET = dpg_pkg::DIGIT_COUNT_RESET;

    localparam bit REQ_RESTART      = 1'b1;
    localparam bit REQ_STEP         = 1'b0;
    localparam int MAX_IDLE         = 12;
    localparam int DRAIN_CYCLES     = 10;
    localparam int STALL_LIMIT      = 2000;
    localparam int TOTAL_ITEMS      = 1900;
    localparam int MAX_REPORTS      = 10;
    localparam int N_DIGITS         = dpg_pkg::MAX_DIGITS_DEF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_perm_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_restart;
    logic               o_valid;
    logic               i_stall;
    logic [VALUE_W-1:0] o_perm_value;
    logic               o_is_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;

    descending_permutation_generator_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_restart    (i_restart),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_perm_value (o_perm_value),
        .o_is_last    (o_is_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the generator state.
    logic [DIGIT_W-1:0] perm_digits [N_DIGITS];
    logic [CFG_W-1:0]   count_reg;
    bit                 seq_running;

    t_perm_word expected_perms [$];

    bit quiet;
    int stall_left;
    int n_sent, n_restarts, n_results, n_lasts, n_cfg_writes;
    int n_mismatch, n_unexpected;

    function automatic int effective_count(input logic [CFG_W-1:0] c);
        if (c < 1) return 1;
        if (c > N_DIGITS) return N_DIGITS;
        return int'(c);
    endfunction

    function automatic int draw_idle();
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Applies one request word to the shadow state; emit tells whether a
    // result word is due.
    function automatic void step_permutation(input bit restart, output bit emit,
                                             output t_perm_word res);
        int n, i, j, lo, hi;
        logic [DIGIT_W-1:0] t;
        bit found;
        logic [VALUE_W-1:0] v;
        bit last;
        n = effective_count(count_reg);
        emit = 1'b0;
        res = '0;
        if (restart) begin
            for (int k = 0; k < n; k++) perm_digits[k] = DIGIT_W'(n - k);
        end else begin
            if (!seq_running) return;
            found = 1'b0;
            i = n - 1;
            while (i > 0 && !found) begin
                if (perm_digits[i-1] > perm_digits[i]) found = 1'b1;
                else i--;
            end
            if (!found) begin
                seq_running = 1'b0;
                return;
            end
            i--;
            // Swap the pivot with the rightmost smaller digit, then reverse the tail.
            j = n - 1;
            while (j > i && perm_digits[j] >= perm_digits[i]) j--;
            t = perm_digits[i];
            perm_digits[i] = perm_digits[j];
            perm_digits[j] = t;
            lo = i + 1;
            hi = n - 1;
            while (lo < hi) begin
                t = perm_digits[lo];
                perm_digits[lo] = perm_digits[hi];
                perm_digits[hi] = t;
                lo++;
                hi--;
            end
        end
        last = 1'b1;
        v = '0;
        for (int k = 0; k < n; k++) begin
            if (perm_digits[k] != DIGIT_W'(k + 1)) last = 1'b0;
            v = VALUE_W'(v * RADIX + perm_digits[k]);
        end
        seq_running = !last;
        emit = 1'b1;
        res.value = v;
        res.last = last;
    endfunction

    // Sends one request word after a random gap and predicts its result.
    task automatic send_request(input bit restart);
        int gap;
        bit emit;
        t_perm_word res;
        gap = draw_idle();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        step_permutation(restart, emit, res);
        if (emit) expected_perms.push_back(res);
        n_sent++;
        if (restart) n_restarts++;
    endtask

    // Writes the digit count once the pipeline has drained.
    task automatic write_digit_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_perms.size() != 0) @(negedge i_clk);
        // A step that yields nothing may still be in flight.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg = value;
        seq_running = 1'b0;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker: every accepted word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_perm_word exp_word;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_is_last) n_lasts++;
            if (expected_perms.size() == 0) begin
                n_unexpected++;
                if (n_mismatch + n_unexpected <= MAX_REPORTS)
                    $display("%0t: unexpected word value=%0d last=%0b",
                             $realtime, o_perm_value, o_is_last);
            end else begin
                exp_word = expected_perms.pop_front();
                if (o_perm_value !== exp_word.value || o_is_last !== exp_word.last) begin
                    n_mismatch++;
                    if (n_mismatch + n_unexpected <= MAX_REPORTS)
                        $display("%0t: mismatch value exp=%0d got=%0d, last exp=%0b got=%0b",
                                 $realtime, exp_word.value, o_perm_value,
                                 exp_word.last, o_is_last);
                end
            end
            stall_left = draw_idle();
        end
    end

    // Receiver back-pressure, drawn anew after each accepted result word.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run if no handshake completes for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Default count of three: a step with no sequence, full walk, requests past the end, restarts.
    task automatic test_default_count();
        send_request(REQ_STEP);
        send_request(REQ_RESTART);
        repeat (5) send_request(REQ_STEP);
        send_request(REQ_STEP);
        send_request(REQ_STEP);
        send_request(REQ_RESTART);
        send_request(REQ_STEP);
        send_request(REQ_RESTART);
    endtask

    // Count extremes, clamping, and a register write that ends a sequence.
    task automatic test_count_limits();
        write_digit_count(CFG_W'(0));
        send_request(REQ_RESTART);
        send_request(REQ_STEP);
        write_digit_count(CFG_W'(15));
        send_request(REQ_RESTART);
        send_request(REQ_STEP);
        send_request(REQ_STEP);
        write_digit_count(CFG_W'(9));
        send_request(REQ_STEP);
        send_request(REQ_RESTART);
        send_request(REQ_STEP);
        write_digit_count(CFG_W'(1));
        send_request(REQ_RESTART);
        write_digit_count(CFG_W'(2));
        send_request(REQ_RESTART);
        send_request(REQ_STEP);
        send_request(REQ_STEP);
    endtask

    // Random phases: a fresh count, then mostly restart-and-walk sequences
    // with some noise. Small counts are often walked to the end.
    task automatic test_random_walks();
        int pick, n, perms, steps;
        logic [CFG_W-1:0] cnt;
        while (n_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) cnt = CFG_W'($urandom_range(1, 5));
            else if (pick < 8) cnt = CFG_W'($urandom_range(6, 9));
            else if (pick == 8) cnt = CFG_W'($urandom_range(10, 15));
            else cnt = CFG_W'(0);
            quiet = ($urandom_range(0, 3) == 0);
            write_digit_count(cnt);
            n = effective_count(cnt);
            perms = 1;
            for (int k = 2; k <= n; k++) perms *= k;
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8)) send_request(1'($urandom_range(0, 1)));
                end else begin
                    send_request(REQ_RESTART);
                    if (perms <= 120 && $urandom_range(0, 1) == 1)
                        steps = perms + $urandom_range(0, 2);
                    else
                        steps = $urandom_range(0, (perms + 1 < 40) ? perms + 1 : 40);
                    repeat (steps) send_request(REQ_STEP);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_restart = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        quiet = 1'b0;
        stall_left = 0;
        n_sent = 0;
        n_restarts = 0;
        n_results = 0;
        n_lasts = 0;
        n_cfg_writes = 0;
        n_mismatch = 0;
        n_unexpected = 0;
        count_reg = DIGIT_COUNT_RESET;
        seq_running = 1'b0;
        for (int k = 0; k < N_DIGITS; k++) perm_digits[k] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_count();
        test_count_limits();
        test_random_walks();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_perms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d restarts) over %0d digit count writes.",
                 n_sent, n_restarts, n_cfg_writes);
        $display("Checked %0d permutation words, %0d of them ends of sequence;",
                 n_results, n_lasts);
        $display("%0d bad, %0d stray, %0d missing.",
                 n_mismatch, n_unexpected, expected_perms.size());
        if (n_mismatch == 0 && n_unexpected == 0 && expected_perms.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
